// File: hw/rtl/pcdb_pkg.sv
`timescale 1ns / 1ps

package pcdb_pkg;

  localparam int RING_DEPTH_DEF   = 256;
  localparam int PAYLOAD_BITS_DEF = 32;

  localparam logic [2:0] OPC_ROLL    = 3'd0;
  localparam logic [2:0] OPC_FREEZE  = 3'd1;
  localparam logic [2:0] OPC_QUERY   = 3'd2;
  localparam logic [2:0] OPC_READ    = 3'd3;
  localparam logic [2:0] OPC_RELEASE = 3'd4;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_INVALID = 1'b1;

  typedef enum logic [2:0] {
    OPK_ROLL,
    OPK_FREEZE,
    OPK_QUERY,
    OPK_READ,
    OPK_RELEASE,
    OPK_BAD
  } op_kind_t;

  typedef enum logic [1:0] {
    MODE_FREE    = 2'd0,
    MODE_ROLLING = 2'd1,
    MODE_FROZEN  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_TRIM,
    S_LAST,
    S_FETCH
  } state_t;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [63:0] seq_value;
    logic [31:0] frame_payload;
    logic [31:0] session_generation;
    logic [63:0] session_min_seq;
    logic [1:0]  snap_bank;
    logic [63:0] snap_first_seq;
    logic [8:0]  snap_count;
    logic [7:0]  frame_index;
  } in_t;

  typedef struct packed {
    logic        status_code;
    logic [63:0] out_first_seq;
    logic [8:0]  out_count;
    logic        out_bank;
    logic [63:0] out_frame_seq;
    logic [31:0] out_frame_payload;
    logic        cut_hit;
    logic [63:0] newest_kept_seq;
    logic [63:0] trigger_echo_seq;
  } out_t;

  typedef struct packed {
    op_kind_t kind;
    in_t      f;
  } q_item_t;

  typedef struct packed {
    logic    valid;
    q_item_t item;
  } q_head_t;

endpackage

// File: hw/rtl/pretrigger_capture_double_bank.sv
`timescale 1ns / 1ps
// Each item is popped from the input queue in S_IDLE and run in S_EXEC; roll, snapshot
// query, release and bad opcodes load the result there, a valid frame read adds S_FETCH,
// and a freeze walks S_TRIM and loads in S_LAST; items run one at a time, paced by the
// single read port of the frame memories and the one-frame-per-cycle freeze trim walk.
// A 2-entry input queue keeps taking beats while a result waits on the output register.
// Reset clears bank records and control; frame memories are not cleared and need no pass.

module pretrigger_capture_double_bank #(
  parameter int RING_DEPTH   = pcdb_pkg::RING_DEPTH_DEF,
  parameter int PAYLOAD_BITS = pcdb_pkg::PAYLOAD_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  pcdb_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output pcdb_pkg::out_t out_data
);

  pcdb_pkg::q_head_t head;
  logic              pop;

  pcdb_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .head     (head),
    .pop      (pop)
  );

  pcdb_back #(
    .RING_DEPTH   (RING_DEPTH),
    .PAYLOAD_BITS (PAYLOAD_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hw/rtl/pcdb_front.sv
`timescale 1ns / 1ps

module pcdb_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pcdb_pkg::in_t     in_data,
  output pcdb_pkg::q_head_t head,
  input  logic              pop
);

  pcdb_pkg::q_item_t q [2];
  logic [1:0] cnt;
  logic       wp;
  logic       rp;
  logic       push;
  pcdb_pkg::op_kind_t kind;

  always_comb begin
    case (in_data.opcode)
      pcdb_pkg::OPC_ROLL:    kind = pcdb_pkg::OPK_ROLL;
      pcdb_pkg::OPC_FREEZE:  kind = pcdb_pkg::OPK_FREEZE;
      pcdb_pkg::OPC_QUERY:   kind = pcdb_pkg::OPK_QUERY;
      pcdb_pkg::OPC_READ:    kind = pcdb_pkg::OPK_READ;
      pcdb_pkg::OPC_RELEASE: kind = pcdb_pkg::OPK_RELEASE;
      default:               kind = pcdb_pkg::OPK_BAD;
    endcase
  end

  assign in_ready   = (cnt != 2'd2);
  assign push       = in_valid && in_ready;
  assign head.valid = (cnt != 2'd0);
  assign head.item  = q[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
      wp  <= 1'b0;
      rp  <= 1'b0;
    end else begin
      if (push) begin
        q[wp].kind <= kind;
        q[wp].f    <= in_data;
        wp         <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      if (push && !pop) begin
        cnt <= cnt + 2'd1;
      end else if (pop && !push) begin
        cnt <= cnt - 2'd1;
      end
    end
  end

endmodule

// File: hw/rtl/pcdb_back.sv
`timescale 1ns / 1ps

module pcdb_back #(
  parameter int RING_DEPTH   = pcdb_pkg::RING_DEPTH_DEF,
  parameter int PAYLOAD_BITS = pcdb_pkg::PAYLOAD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  pcdb_pkg::q_head_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output pcdb_pkg::out_t    out_data
);

  localparam int PW    = $clog2(RING_DEPTH);
  localparam int FW    = $clog2(RING_DEPTH + 1);
  localparam int EW    = PW + 2;
  localparam int SLOTS = 2 * RING_DEPTH;
  localparam int AW    = $clog2(SLOTS);
  localparam logic [EW-1:0] DEPTH_E = EW'(RING_DEPTH);
  localparam logic [FW-1:0] DEPTH_F = FW'(RING_DEPTH);
  localparam logic [31:0] PMASK =
    (PAYLOAD_BITS >= 32) ? 32'hFFFF_FFFF : 32'((64'd1 << PAYLOAD_BITS) - 64'd1);

  function automatic logic [PW-1:0] wrap(input logic [EW-1:0] x);
    logic [EW-1:0] y;
    y = (x >= DEPTH_E) ? x - DEPTH_E : x;
    return y[PW-1:0];
  endfunction

  function automatic logic [AW-1:0] slot(input logic b, input logic [PW-1:0] p);
    return b ? AW'(p) + AW'(RING_DEPTH) : AW'(p);
  endfunction

  logic [63:0] seq_mem [SLOTS];
  logic [31:0] dat_mem [SLOTS];
  logic [63:0] seq_rd;
  logic [31:0] dat_rd;
  logic        we;
  logic [AW-1:0] wa;
  logic [AW-1:0] ra;

  pcdb_pkg::state_t  state;
  pcdb_pkg::state_t  state_next;
  pcdb_pkg::q_item_t cur;
  logic [63:0]       thr;
  logic [63:0]       thr_base;
  logic [PW-1:0]     bank_start [2];
  logic [FW-1:0]     bank_fill [2];
  pcdb_pkg::mode_t   bank_mode [2];
  logic [31:0]       owner_gen [2];
  logic [63:0]       head_seq [2];
  logic [1:0]        owned;
  logic              rolling_bank;

  logic          rb;
  logic          ob;
  logic          hit0;
  logic          hit1;
  logic          found;
  logic          fb;
  logic          rd_ok;
  logic          trim_go;
  logic [PW-1:0] start_inc;
  logic [PW-1:0] last_pos;
  logic [PW-1:0] roll_pos;
  logic [PW+7:0] idx_w;
  logic [PW-1:0] idx_p;
  logic          res_load;
  pcdb_pkg::out_t res;

  always_ff @(posedge clk) begin
    if (we) begin
      seq_mem[wa] <= cur.f.seq_value;
      dat_mem[wa] <= cur.f.frame_payload & PMASK;
    end
    seq_rd <= seq_mem[ra];
    dat_rd <= dat_mem[ra];
  end

  assign rb    = rolling_bank;
  assign ob    = ~rolling_bank;
  assign hit0  = owned[0] && (owner_gen[0] == cur.f.session_generation) &&
                 (cur.f.session_generation != 32'd0);
  assign hit1  = owned[1] && (owner_gen[1] == cur.f.session_generation) &&
                 (cur.f.session_generation != 32'd0);
  assign found = hit0 || hit1;
  assign fb    = !hit0;
  assign idx_w = {{PW{1'b0}}, cur.f.frame_index};
  assign idx_p = idx_w[PW-1:0];
  assign rd_ok = found && !cur.f.snap_bank[1] && (cur.f.snap_bank[0] == fb) &&
                 (bank_mode[fb] == pcdb_pkg::MODE_FROZEN) &&
                 (head_seq[fb] == cur.f.snap_first_seq) &&
                 (32'(bank_fill[fb]) == 32'(cur.f.snap_count)) &&
                 (32'(cur.f.frame_index) < 32'(bank_fill[fb]));
  assign trim_go   = (bank_fill[rb] != '0) && (seq_rd < thr);
  assign start_inc = wrap(EW'(bank_start[rb]) + EW'(1));
  assign last_pos  = wrap(EW'(bank_start[rb]) + EW'(bank_fill[rb]) - EW'(1));
  assign roll_pos  = wrap(EW'(bank_start[rb]) + EW'(bank_fill[rb]));
  assign thr_base  = (head.item.f.seq_value > 64'(RING_DEPTH)) ?
                     head.item.f.seq_value - 64'(RING_DEPTH) : 64'd0;

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    we         = 1'b0;
    wa         = slot(rb, roll_pos);
    ra         = slot(rb, bank_start[rb]);
    res        = '0;
    res.status_code = pcdb_pkg::STATUS_INVALID;
    res_load   = 1'b0;
    case (state)
      pcdb_pkg::S_IDLE: begin
        if (head.valid && (!out_valid || out_ready)) begin
          pop        = 1'b1;
          state_next = pcdb_pkg::S_EXEC;
        end
      end
      pcdb_pkg::S_EXEC: begin
        state_next = pcdb_pkg::S_IDLE;
        case (cur.kind)
          pcdb_pkg::OPK_ROLL: begin
            we              = 1'b1;
            res.status_code = pcdb_pkg::STATUS_OK;
            res_load        = 1'b1;
          end
          pcdb_pkg::OPK_FREEZE: begin
            state_next = pcdb_pkg::S_TRIM;
          end
          pcdb_pkg::OPK_QUERY: begin
            res_load = 1'b1;
            if (found) begin
              res.status_code   = pcdb_pkg::STATUS_OK;
              res.out_first_seq = head_seq[fb];
              res.out_count     = 9'(bank_fill[fb]);
              res.out_bank      = fb;
            end
          end
          pcdb_pkg::OPK_READ: begin
            if (rd_ok) begin
              ra         = slot(fb, wrap(EW'(bank_start[fb]) + EW'(idx_p)));
              state_next = pcdb_pkg::S_FETCH;
            end else begin
              res_load = 1'b1;
            end
          end
          pcdb_pkg::OPK_RELEASE: begin
            res_load = 1'b1;
            if (found) begin
              res.status_code = pcdb_pkg::STATUS_OK;
              res.out_bank    = fb;
            end
          end
          default: begin
            res_load = 1'b1;
          end
        endcase
      end
      pcdb_pkg::S_TRIM: begin
        if (trim_go) begin
          ra = slot(rb, start_inc);
        end else begin
          ra         = slot(rb, last_pos);
          state_next = pcdb_pkg::S_LAST;
        end
      end
      pcdb_pkg::S_LAST: begin
        res.status_code      = pcdb_pkg::STATUS_OK;
        res.out_first_seq    = head_seq[rb];
        res.out_count        = 9'(bank_fill[rb]);
        res.out_bank         = rb;
        res.trigger_echo_seq = cur.f.seq_value;
        if (bank_fill[rb] != '0) begin
          res.cut_hit         = 1'b1;
          res.newest_kept_seq = seq_rd;
        end
        res_load   = 1'b1;
        state_next = pcdb_pkg::S_IDLE;
      end
      pcdb_pkg::S_FETCH: begin
        res.status_code       = pcdb_pkg::STATUS_OK;
        res.out_bank          = cur.f.snap_bank[0];
        res.out_frame_seq     = seq_rd;
        res.out_frame_payload = dat_rd;
        res_load              = 1'b1;
        state_next            = pcdb_pkg::S_IDLE;
      end
      default: begin
        state_next = pcdb_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pcdb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bank_start[0] <= '0;
      bank_start[1] <= '0;
      bank_fill[0]  <= '0;
      bank_fill[1]  <= '0;
      bank_mode[0]  <= pcdb_pkg::MODE_ROLLING;
      bank_mode[1]  <= pcdb_pkg::MODE_FREE;
      owner_gen[0]  <= '0;
      owner_gen[1]  <= '0;
      head_seq[0]   <= '0;
      head_seq[1]   <= '0;
      owned         <= '0;
      rolling_bank  <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (res_load) begin
        out_valid <= 1'b1;
        out_data  <= res;
      end
      if (pop) begin
        cur <= head.item;
        thr <= (head.item.f.session_min_seq > thr_base) ?
               head.item.f.session_min_seq : thr_base;
      end
      case (state)
        pcdb_pkg::S_EXEC: begin
          if (cur.kind == pcdb_pkg::OPK_ROLL) begin
            if (bank_fill[rb] < DEPTH_F) begin
              bank_fill[rb] <= bank_fill[rb] + FW'(1);
            end else begin
              bank_start[rb] <= start_inc;
            end
          end
          if (cur.kind == pcdb_pkg::OPK_RELEASE && found) begin
            bank_mode[fb] <= pcdb_pkg::MODE_FREE;
            owned[fb]     <= 1'b0;
          end
        end
        pcdb_pkg::S_TRIM: begin
          if (trim_go) begin
            bank_start[rb] <= start_inc;
            bank_fill[rb]  <= bank_fill[rb] - FW'(1);
          end else begin
            head_seq[rb] <= (bank_fill[rb] != '0) ? seq_rd : cur.f.seq_value;
          end
        end
        pcdb_pkg::S_LAST: begin
          bank_mode[rb]  <= pcdb_pkg::MODE_FROZEN;
          owner_gen[rb]  <= cur.f.session_generation;
          owned[rb]      <= 1'b1;
          rolling_bank   <= ob;
          bank_mode[ob]  <= pcdb_pkg::MODE_ROLLING;
          bank_start[ob] <= '0;
          bank_fill[ob]  <= '0;
          owner_gen[ob]  <= '0;
          owned[ob]      <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_one_owner: assert property (@(posedge clk) disable iff (rst)
    !(owned[0] && owned[1]))
    else $error("both banks owned");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    (bank_fill[0] <= DEPTH_F) && (bank_fill[1] <= DEPTH_F))
    else $error("bank fill above ring depth");

  a_rolling_mode: assert property (@(posedge clk) disable iff (rst)
    (bank_mode[rolling_bank] == pcdb_pkg::MODE_ROLLING) && !owned[rolling_bank])
    else $error("rolling bank not in rolling mode");

  a_busy_out_free: assert property (@(posedge clk) disable iff (rst)
    (state != pcdb_pkg::S_IDLE) |-> !out_valid)
    else $error("result pending while an item is in work");
`endif

endmodule
